// ===== hw/rtl/hsl_to_rgba_converter_macros.svh =====
// assertion macros shared by the colour converter
`ifndef HSL_TO_RGBA_CONVERTER_MACROS_SVH
`define HSL_TO_RGBA_CONVERTER_MACROS_SVH

// same-cycle implication, off while in reset
`define HSL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while in reset
`define HSL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/hsl2rgba_pkg.sv =====
// shared types and constants of the hsl to rgba converter
`default_nettype none

package hsl2rgba_pkg;

  localparam int DEF_FRACTION_BITS      = 12;
  localparam int DEF_HUE_SUBDEGREE_BITS = 4;
  localparam int IN_FIELD_W             = 13;
  localparam int OUT_FIELD_W            = 8;
  localparam int NUM_STAGES             = 6;

  typedef struct packed {
    logic [IN_FIELD_W-1:0] hue;
    logic [IN_FIELD_W-1:0] saturation;
    logic [IN_FIELD_W-1:0] luminance;
    logic [IN_FIELD_W-1:0] opacity;
  } hsl_in_t;

  typedef struct packed {
    logic [OUT_FIELD_W-1:0] red;
    logic [OUT_FIELD_W-1:0] green;
    logic [OUT_FIELD_W-1:0] blue;
    logic [OUT_FIELD_W-1:0] alpha_out;
  } rgba_out_t;

  // load enables of the six pipeline stages
  typedef struct packed {
    logic s6;
    logic s5;
    logic s4;
    logic s3;
    logic s2;
    logic s1;
  } stage_en_t;

  // 60 degree hue sectors
  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } hue_sector_t;

endpackage

`default_nettype wire

// ===== hw/rtl/hsl2rgba_prep.sv =====
// stage 1: input saturation, hue sector and weight, lightness fold, alpha scale
`default_nettype none

module hsl2rgba_prep import hsl2rgba_pkg::*; #(
  parameter int FRACTION_BITS      = DEF_FRACTION_BITS,
  parameter int HUE_SUBDEGREE_BITS = DEF_HUE_SUBDEGREE_BITS
) (
  input  wire logic                                    clk,
  input  wire stage_en_t                               en,
  input  wire hsl_in_t                                 in_data,
  output logic [$clog2((60 << HUE_SUBDEGREE_BITS) + 1)-1:0] xw,
  output logic [FRACTION_BITS:0]                       onemd,
  output logic [FRACTION_BITS:0]                       sat,
  output logic [FRACTION_BITS:0]                       lum,
  output hue_sector_t                                  sec,
  output logic [OUT_FIELD_W-1:0]                       alpha
);

  localparam int ONE     = 1 << FRACTION_BITS;
  localparam int SPAN    = 60 << HUE_SUBDEGREE_BITS;
  localparam int HUE_MAX = 360 * (1 << HUE_SUBDEGREE_BITS) - 1;
  localparam int HW      = $clog2(HUE_MAX + 1);
  localparam int SW      = $clog2(SPAN + 1);
  localparam int FW      = FRACTION_BITS + 1;
  localparam int FW1     = FW + 1;
  localparam int AW      = FW + 8;

  logic [HW-1:0]   h;
  logic [HW-1:0]   base;
  logic [HW-1:0]   r;
  logic [FW-1:0]   s_sat;
  logic [FW-1:0]   l_sat;
  logic [FW-1:0]   a_sat;
  logic [FW1-1:0]  twol;
  logic [AW-1:0]   a255;
  hue_sector_t     sec_nxt;
  logic [SW-1:0]   xw_nxt;
  logic [FW-1:0]   onemd_nxt;

  logic [SW-1:0]          xw_r;
  logic [FW-1:0]          onemd_r;
  logic [FW-1:0]          sat_r;
  logic [FW-1:0]          lum_r;
  hue_sector_t            sec_r;
  logic [OUT_FIELD_W-1:0] alpha_r;

  always_comb begin
    h     = (32'(in_data.hue) > 32'(HUE_MAX)) ? HW'(HUE_MAX) : HW'(in_data.hue);
    s_sat = (32'(in_data.saturation) > 32'(ONE)) ? FW'(ONE) : FW'(in_data.saturation);
    l_sat = (32'(in_data.luminance) > 32'(ONE)) ? FW'(ONE) : FW'(in_data.luminance);
    a_sat = (32'(in_data.opacity) > 32'(ONE)) ? FW'(ONE) : FW'(in_data.opacity);

    // sector and start of its 120 degree pair
    if (h >= HW'(5 * SPAN)) begin
      sec_nxt = SEC_MAG_RED;
      base    = HW'(4 * SPAN);
    end else if (h >= HW'(4 * SPAN)) begin
      sec_nxt = SEC_BLU_MAG;
      base    = HW'(4 * SPAN);
    end else if (h >= HW'(3 * SPAN)) begin
      sec_nxt = SEC_CYN_BLU;
      base    = HW'(2 * SPAN);
    end else if (h >= HW'(2 * SPAN)) begin
      sec_nxt = SEC_GRN_CYN;
      base    = HW'(2 * SPAN);
    end else if (h >= HW'(SPAN)) begin
      sec_nxt = SEC_YEL_GRN;
      base    = '0;
    end else begin
      sec_nxt = SEC_RED_YEL;
      base    = '0;
    end
    r = h - base;

    // weight of the secondary colour, 0 at the pair ends, span in the middle
    xw_nxt = (r >= HW'(SPAN)) ? SW'(HW'(2 * SPAN) - r) : SW'(r);

    // 1 - |2l - 1|
    twol      = {l_sat, 1'b0};
    onemd_nxt = (twol < FW1'(ONE)) ? FW'(twol) : FW'(FW1'(2 * ONE) - twol);

    a255 = {a_sat, 8'd0} - {8'd0, a_sat};
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      xw_r    <= xw_nxt;
      onemd_r <= onemd_nxt;
      sat_r   <= s_sat;
      lum_r   <= l_sat;
      sec_r   <= sec_nxt;
      alpha_r <= a255[FRACTION_BITS+7:FRACTION_BITS];
    end
  end

  assign xw    = xw_r;
  assign onemd = onemd_r;
  assign sat   = sat_r;
  assign lum   = lum_r;
  assign sec   = sec_r;
  assign alpha = alpha_r;

endmodule

`default_nettype wire

// ===== hw/rtl/hsl2rgba_chroma.sv =====
// stages 2 to 4: chroma, secondary and offset terms
`default_nettype none

module hsl2rgba_chroma import hsl2rgba_pkg::*; #(
  parameter int FRACTION_BITS      = DEF_FRACTION_BITS,
  parameter int HUE_SUBDEGREE_BITS = DEF_HUE_SUBDEGREE_BITS
) (
  input  wire logic                                              clk,
  input  wire stage_en_t                                         en,
  input  wire logic [$clog2((60 << HUE_SUBDEGREE_BITS) + 1)-1:0] xw,
  input  wire logic [FRACTION_BITS:0]                            onemd,
  input  wire logic [FRACTION_BITS:0]                            sat,
  input  wire logic [FRACTION_BITS:0]                            lum,
  input  wire hue_sector_t                                       sec_in,
  input  wire logic [OUT_FIELD_W-1:0]                            alpha_in,
  output logic [2*FRACTION_BITS+HUE_SUBDEGREE_BITS+5:0]          cv,
  output logic [2*FRACTION_BITS+HUE_SUBDEGREE_BITS+5:0]          xv,
  output logic [2*FRACTION_BITS+HUE_SUBDEGREE_BITS+5:0]          mv,
  output hue_sector_t                                            sec_out,
  output logic [OUT_FIELD_W-1:0]                                 alpha_out
);

  localparam int SPAN = 60 << HUE_SUBDEGREE_BITS;
  localparam int SW   = $clog2(SPAN + 1);
  localparam int FW   = FRACTION_BITS + 1;
  localparam int C2W  = 2 * FRACTION_BITS + 1;
  localparam int NW   = 2 * FRACTION_BITS + HUE_SUBDEGREE_BITS + 6;

  logic [2*FW-1:0] prod;

  // stage 2
  logic [C2W-1:0]         c2_r;
  logic [SW-1:0]          xw2_r;
  logic [FW-1:0]          lum2_r;
  hue_sector_t            sec2_r;
  logic [OUT_FIELD_W-1:0] alpha2_r;

  // stage 3
  logic [NW-1:0]          ch_nxt;
  logic [NW-1:0]          xv_nxt;
  logic [NW-1:0]          lo_nxt;
  logic [NW-1:0]          ch_r;
  logic [NW-1:0]          xv3_r;
  logic [NW-1:0]          lo_r;
  hue_sector_t            sec3_r;
  logic [OUT_FIELD_W-1:0] alpha3_r;

  // stage 4
  logic [NW-1:0]          cv_r;
  logic [NW-1:0]          xv4_r;
  logic [NW-1:0]          mv_r;
  hue_sector_t            sec4_r;
  logic [OUT_FIELD_W-1:0] alpha4_r;

  assign prod = {{FW{1'b0}}, onemd} * {{FW{1'b0}}, sat};

  always_ff @(posedge clk) begin
    if (en.s2) begin
      c2_r     <= prod[C2W-1:0];
      xw2_r    <= xw;
      lum2_r   <= lum;
      sec2_r   <= sec_in;
      alpha2_r <= alpha_in;
    end
  end

  // all terms in units of one over (one squared times span)
  always_comb begin
    ch_nxt = NW'(c2_r) * NW'(SPAN / 2);
    xv_nxt = NW'(c2_r) * NW'(xw2_r);
    lo_nxt = (NW'(lum2_r) * NW'(SPAN)) << FRACTION_BITS;
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      ch_r     <= ch_nxt;
      xv3_r    <= xv_nxt;
      lo_r     <= lo_nxt;
      sec3_r   <= sec2_r;
      alpha3_r <= alpha2_r;
    end
  end

  // offset m = l - c/2, never negative
  always_ff @(posedge clk) begin
    if (en.s4) begin
      cv_r     <= {ch_r[NW-2:0], 1'b0};
      xv4_r    <= xv3_r;
      mv_r     <= lo_r - ch_r;
      sec4_r   <= sec3_r;
      alpha4_r <= alpha3_r;
    end
  end

  assign cv        = cv_r;
  assign xv        = xv4_r;
  assign mv        = mv_r;
  assign sec_out   = sec4_r;
  assign alpha_out = alpha4_r;

endmodule

`default_nettype wire

// ===== hw/rtl/hsl2rgba_blend.sv =====
// stages 5 and 6: sector placement, offset add, scale by 255 and clamp
`default_nettype none

module hsl2rgba_blend import hsl2rgba_pkg::*; #(
  parameter int FRACTION_BITS      = DEF_FRACTION_BITS,
  parameter int HUE_SUBDEGREE_BITS = DEF_HUE_SUBDEGREE_BITS
) (
  input  wire logic                                     clk,
  input  wire stage_en_t                                en,
  input  wire logic [2*FRACTION_BITS+HUE_SUBDEGREE_BITS+5:0] cv,
  input  wire logic [2*FRACTION_BITS+HUE_SUBDEGREE_BITS+5:0] xv,
  input  wire logic [2*FRACTION_BITS+HUE_SUBDEGREE_BITS+5:0] mv,
  input  wire hue_sector_t                              sec,
  input  wire logic [OUT_FIELD_W-1:0]                   alpha,
  output rgba_out_t                                     pix
);

  localparam int NW = 2 * FRACTION_BITS + HUE_SUBDEGREE_BITS + 6;
  // full scale is 15 * 2^K, so x * 255 / full scale is x * 17 >> K
  localparam int K  = NW - 4;

  logic [NW-1:0] rv;
  logic [NW-1:0] gv;
  logic [NW-1:0] bv;

  logic [NW-1:0]          nr_r;
  logic [NW-1:0]          ng_r;
  logic [NW-1:0]          nb_r;
  logic [OUT_FIELD_W-1:0] alpha5_r;
  rgba_out_t              pix_r;

  function automatic logic [OUT_FIELD_W-1:0] scale8(input logic [NW-1:0] n);
    logic [NW+4:0] p;
    logic [8:0]    q;
    p      = {1'b0, n, 4'd0} + {5'd0, n};
    q      = p[K+8:K];
    scale8 = q[8] ? 8'hFF : q[7:0];
  endfunction

  always_comb begin
    unique case (sec)
      SEC_RED_YEL: begin rv = cv; gv = xv; bv = '0; end
      SEC_YEL_GRN: begin rv = xv; gv = cv; bv = '0; end
      SEC_GRN_CYN: begin rv = '0; gv = cv; bv = xv; end
      SEC_CYN_BLU: begin rv = '0; gv = xv; bv = cv; end
      SEC_BLU_MAG: begin rv = xv; gv = '0; bv = cv; end
      default:     begin rv = cv; gv = '0; bv = xv; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en.s5) begin
      nr_r     <= rv + mv;
      ng_r     <= gv + mv;
      nb_r     <= bv + mv;
      alpha5_r <= alpha;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s6) begin
      pix_r.red       <= scale8(nr_r);
      pix_r.green     <= scale8(ng_r);
      pix_r.blue      <= scale8(nb_r);
      pix_r.alpha_out <= alpha5_r;
    end
  end

  assign pix = pix_r;

endmodule

`default_nettype wire

// ===== hw/rtl/hsl_to_rgba_converter.sv =====
// a result appears on out_valid once its input transfer has passed the six register stages
// throughput: one colour per cycle while out_stall is low; six register stages, stage 2 holding the
// chroma multiply and stage 3 the hue weight multiply
// a stalled output fills the pipeline's empty stages before in_stall rises
// reset clears only the stage valid bits; data registers are not reset
`default_nettype none

`include "hsl_to_rgba_converter_macros.svh"

module hsl_to_rgba_converter import hsl2rgba_pkg::*; #(
  parameter int FRACTION_BITS      = DEF_FRACTION_BITS,
  parameter int HUE_SUBDEGREE_BITS = DEF_HUE_SUBDEGREE_BITS
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire hsl_in_t   in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output rgba_out_t      out_data
);

  localparam int SW = $clog2((60 << HUE_SUBDEGREE_BITS) + 1);
  localparam int FW = FRACTION_BITS + 1;
  localparam int NW = 2 * FRACTION_BITS + HUE_SUBDEGREE_BITS + 6;

  logic [NUM_STAGES-1:0] vld_r;
  logic [NUM_STAGES-1:0] vld_nxt;
  logic [NUM_STAGES-1:0] rdy;
  stage_en_t             en;
  logic                  in_xfer;
  logic                  out_xfer;

  logic [SW-1:0]          xw;
  logic [FW-1:0]          onemd;
  logic [FW-1:0]          sat;
  logic [FW-1:0]          lum;
  hue_sector_t            sec1;
  logic [OUT_FIELD_W-1:0] alpha1;
  logic [NW-1:0]          cv;
  logic [NW-1:0]          xv;
  logic [NW-1:0]          mv;
  hue_sector_t            sec4;
  logic [OUT_FIELD_W-1:0] alpha4;

  // a stage moves on when empty or when the one after it moves
  always_comb begin
    rdy[NUM_STAGES-1] = !vld_r[NUM_STAGES-1] || !out_stall;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      rdy[i] = !vld_r[i] || rdy[i+1];
    end
    vld_nxt[0] = rdy[0] ? in_valid : vld_r[0];
    for (int i = 1; i < NUM_STAGES; i++) begin
      vld_nxt[i] = rdy[i] ? vld_r[i-1] : vld_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_comb begin
    en.s1 = rdy[0];
    en.s2 = rdy[1];
    en.s3 = rdy[2];
    en.s4 = rdy[3];
    en.s5 = rdy[4];
    en.s6 = rdy[5];
  end

  assign in_stall  = !rdy[0];
  assign out_valid = vld_r[NUM_STAGES-1];
  assign in_xfer   = in_valid && !in_stall;
  assign out_xfer  = out_valid && !out_stall;

  hsl2rgba_prep #(
    .FRACTION_BITS      (FRACTION_BITS),
    .HUE_SUBDEGREE_BITS (HUE_SUBDEGREE_BITS)
  ) u_prep (
    .clk     (clk),
    .en      (en),
    .in_data (in_data),
    .xw      (xw),
    .onemd   (onemd),
    .sat     (sat),
    .lum     (lum),
    .sec     (sec1),
    .alpha   (alpha1)
  );

  hsl2rgba_chroma #(
    .FRACTION_BITS      (FRACTION_BITS),
    .HUE_SUBDEGREE_BITS (HUE_SUBDEGREE_BITS)
  ) u_chroma (
    .clk       (clk),
    .en        (en),
    .xw        (xw),
    .onemd     (onemd),
    .sat       (sat),
    .lum       (lum),
    .sec_in    (sec1),
    .alpha_in  (alpha1),
    .cv        (cv),
    .xv        (xv),
    .mv        (mv),
    .sec_out   (sec4),
    .alpha_out (alpha4)
  );

  hsl2rgba_blend #(
    .FRACTION_BITS      (FRACTION_BITS),
    .HUE_SUBDEGREE_BITS (HUE_SUBDEGREE_BITS)
  ) u_blend (
    .clk   (clk),
    .en    (en),
    .cv    (cv),
    .xv    (xv),
    .mv    (mv),
    .sec   (sec4),
    .alpha (alpha4),
    .pix   (out_data)
  );

  // input only held off when every stage is full and the output is stalled
  `HSL_ASSERT_NOW(a_stall_only_when_full, clk, rst_n, in_stall, (&vld_r) && out_stall, "in_stall with an empty stage")
  // items in flight change only by transfers in and out
  `HSL_ASSERT_NEXT(a_item_count, clk, rst_n, 1'b1, $countones(vld_r) == $countones($past(vld_r)) + int'($past(in_xfer)) - int'($past(out_xfer)), "item lost or duplicated in pipeline")

endmodule

`default_nettype wire

// ===== test/hsl_to_rgba_converter_tb.sv =====
// testbench of the hsl to rgba converter: directed and random colours checked against a predictor
`timescale 1ns / 100ps

module hsl_to_rgba_converter_tb;
  import hsl2rgba_pkg::*;

  localparam longint unsigned FRAC_ONE = 64'd1 << DEF_FRACTION_BITS;
  localparam longint unsigned HUE_STEP = 64'd1 << DEF_HUE_SUBDEGREE_BITS;
  localparam longint unsigned SECTOR   = 60 * HUE_STEP;
  localparam longint unsigned HUE_TOP  = 360 * HUE_STEP - 1;
  localparam int LONG_HOLD = 200;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  hsl_in_t   in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  rgba_out_t out_data;

  rgba_out_t pending_rgba[$];
  rgba_out_t want_rgba;
  int        mismatch_count = 0;
  bit        gaps_on = 1'b1;
  bit        hold_go = 1'b0;
  bit        hold_done = 1'b0;
  int        rx_left = 0;
  int        rx_gap = 0;
  int        hold_cnt = 0;

  hsl_to_rgba_converter uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always #5 clk = ~clk;

  // floor(num * 255 / den), clamped to 255
  function automatic logic [7:0] scale8(input longint unsigned num, input longint unsigned den);
    longint unsigned q;
    q = (num * 255) / den;
    return (q > 255) ? 8'd255 : q[7:0];
  endfunction

  function automatic rgba_out_t predict_rgba(input hsl_in_t c);
    longint unsigned h, s, l, a, twol, fold, c2, r, t, den, cv, xv, mv, rv, gv, bv;
    rgba_out_t o;
    h = (64'(c.hue) > HUE_TOP) ? HUE_TOP : 64'(c.hue);
    s = (64'(c.saturation) > FRAC_ONE) ? FRAC_ONE : 64'(c.saturation);
    l = (64'(c.luminance) > FRAC_ONE) ? FRAC_ONE : 64'(c.luminance);
    a = (64'(c.opacity) > FRAC_ONE) ? FRAC_ONE : 64'(c.opacity);
    twol = 2 * l;
    fold = (twol >= FRAC_ONE) ? twol - FRAC_ONE : FRAC_ONE - twol;
    c2 = (FRAC_ONE - fold) * s;
    // distance from the middle of the 120 degree pair
    r = h % (2 * SECTOR);
    t = (r >= SECTOR) ? r - SECTOR : SECTOR - r;
    den = FRAC_ONE * FRAC_ONE * SECTOR;
    cv = c2 * SECTOR;
    xv = c2 * (SECTOR - t);
    mv = l * FRAC_ONE * SECTOR - c2 * (SECTOR / 2);
    case (hue_sector_t'(3'(h / SECTOR)))
      SEC_RED_YEL: begin rv = cv; gv = xv; bv = 0;  end
      SEC_YEL_GRN: begin rv = xv; gv = cv; bv = 0;  end
      SEC_GRN_CYN: begin rv = 0;  gv = cv; bv = xv; end
      SEC_CYN_BLU: begin rv = 0;  gv = xv; bv = cv; end
      SEC_BLU_MAG: begin rv = xv; gv = 0;  bv = cv; end
      default: begin rv = cv; gv = 0; bv = xv; end
    endcase
    o.red       = scale8(rv + mv, den);
    o.green     = scale8(gv + mv, den);
    o.blue      = scale8(bv + mv, den);
    o.alpha_out = scale8(a, FRAC_ONE);
    return o;
  endfunction

  function automatic hsl_in_t colour(input int h, input int s, input int l, input int a);
    hsl_in_t c;
    c.hue = IN_FIELD_W'(h);
    c.saturation = IN_FIELD_W'(s);
    c.luminance = IN_FIELD_W'(l);
    c.opacity = IN_FIELD_W'(a);
    return c;
  endfunction

  // mostly in range, some near the limits, some anywhere in the field
  function automatic hsl_in_t rand_colour();
    hsl_in_t c;
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      c = colour($urandom_range(0, 8191), $urandom_range(0, 8191),
                 $urandom_range(0, 8191), $urandom_range(0, 8191));
    end else if (pick == 1) begin
      c.hue = IN_FIELD_W'(SECTOR * $urandom_range(0, 6) - $urandom_range(0, 1));
      c.saturation = IN_FIELD_W'($urandom_range(0, 1) ? FRAC_ONE - $urandom_range(0, 2)
                                                     : 64'($urandom_range(0, 2)));
      c.luminance = IN_FIELD_W'((FRAC_ONE / 2) * $urandom_range(0, 2) + $urandom_range(0, 2) - 1);
      c.opacity = IN_FIELD_W'($urandom_range(0, 1) ? FRAC_ONE - $urandom_range(0, 1)
                                                  : 64'($urandom_range(0, 1)));
    end else begin
      c = colour($urandom_range(0, int'(HUE_TOP)), $urandom_range(0, int'(FRAC_ONE)),
                 $urandom_range(0, int'(FRAC_ONE)), $urandom_range(0, int'(FRAC_ONE)));
    end
    return c;
  endfunction

  // mostly short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_colour(input hsl_in_t c, input bit may_idle);
    int gap;
    in_data  <= c;
    in_valid <= 1'b1;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    pending_rgba.push_back(predict_rgba(c));
    gap = (may_idle && gaps_on) ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_rgba.size() != 0) @(posedge clk);
  endtask

  task automatic test_hue_sectors();
    int hues[9] = '{0, 959, 960, 1919, 1920, 2880, 3840, 4800, 5759};
    foreach (hues[i]) send_colour(colour(hues[i], 4096, 2048, 4096), 1'b1);
  endtask

  task automatic test_fraction_limits();
    send_colour(colour(0, 0, 0, 0), 1'b1);
    send_colour(colour(1000, 4096, 0, 4096), 1'b1);
    send_colour(colour(3000, 4096, 4096, 4096), 1'b1);
    send_colour(colour(2500, 0, 2048, 2048), 1'b1);
    // hue and fractions above their limits saturate
    send_colour(colour(8191, 4096, 2048, 4096), 1'b1);
    send_colour(colour(5760, 8191, 2048, 4097), 1'b1);
    send_colour(colour(4200, 2048, 8191, 8191), 1'b1);
    send_colour(colour(8191, 8191, 8191, 8191), 1'b1);
    send_colour(colour(700, 4097, 4097, 1), 1'b1);
    send_colour(colour(5000, 4095, 2047, 4095), 1'b1);
    send_colour(colour(1440, 4096, 2049, 2048), 1'b1);
  endtask

  // receiver holds off while the sender keeps offering, so the pipeline fills
  task automatic test_back_pressure();
    hold_go <= 1'b1;
    repeat (40) send_colour(rand_colour(), 1'b0);
    in_valid <= 1'b0;
    while (!hold_done) @(posedge clk);
    hold_go <= 1'b0;
    wait_drained();
  endtask

  task automatic test_drain_pauses();
    repeat (3) begin
      repeat (60) send_colour(rand_colour(), 1'b1);
      wait_drained();
    end
  endtask

  task automatic test_random_stream(input int n);
    for (int i = 0; i < n; i++) begin
      if (i % 100 == 0) gaps_on <= ($urandom_range(0, 3) != 0);
      send_colour(rand_colour(), 1'b1);
    end
    gaps_on <= 1'b1;
  endtask

  // receiver side: random stall, or one long hold when asked
  always @(posedge clk) begin
    if (hold_go && !hold_done) begin
      out_stall <= 1'b1;
      hold_cnt++;
      if (hold_cnt >= LONG_HOLD) begin
        hold_done <= 1'b1;
        hold_cnt = 0;
      end
    end else begin
      if (!hold_go) hold_done <= 1'b0;
      if (rx_left > 0) begin
        rx_left--;
      end else if (out_stall) begin
        out_stall <= 1'b0;
        rx_left = $urandom_range(0, 12);
      end else if (gaps_on) begin
        rx_gap = pick_gap();
        if (rx_gap > 0) begin
          out_stall <= 1'b1;
          rx_left = rx_gap - 1;
        end
      end
    end
  end

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // sampled at the falling edge; the transfer completes at the next rising edge
  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_rgba.size() == 0) begin
        $error("result %h with nothing expected", out_data);
        mismatch_count++;
      end else begin
        want_rgba = pending_rgba.pop_front();
        check_field("red", int'(want_rgba.red), int'(out_data.red));
        check_field("green", int'(want_rgba.green), int'(out_data.green));
        check_field("blue", int'(want_rgba.blue), int'(out_data.blue));
        check_field("alpha_out", int'(want_rgba.alpha_out), int'(out_data.alpha_out));
      end
    end
  end

  initial begin
    int waited;
    waited = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_hue_sectors();
    test_fraction_limits();
    test_back_pressure();
    test_drain_pauses();
    test_random_stream(1160);
    in_valid <= 1'b0;
    while (pending_rgba.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (NUM_STAGES + 4) @(posedge clk);
    if (pending_rgba.size() != 0) begin
      $error("%0d results never arrived", pending_rgba.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("** hsl_to_rgba_converter: PASSED **");
    end else begin
      $display("** hsl_to_rgba_converter: FAILED **");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("** hsl_to_rgba_converter: FAILED **");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/hsl2rgba_pkg.sv
hw/rtl/hsl2rgba_prep.sv
hw/rtl/hsl2rgba_chroma.sv
hw/rtl/hsl2rgba_blend.sv
hw/rtl/hsl_to_rgba_converter.sv
test/hsl_to_rgba_converter_tb.sv
